[src/clns_pkg.sv]
// shared types and constants for the character lcd nibble sequencer
package clns_pkg;

    localparam int TIMER_BITS_DEF = 20;
    localparam int WAIT_BITS      = 20;
    localparam int ADDR_BITS      = 5;
    localparam int DATA_BITS      = 32;

    localparam logic [2:0] ACT_TICK   = 3'd0;
    localparam logic [2:0] ACT_CMD    = 3'd1;
    localparam logic [2:0] ACT_DATA   = 3'd2;
    localparam logic [2:0] ACT_CURSOR = 3'd3;
    localparam logic [2:0] ACT_INIT   = 3'd4;

    localparam logic [2:0] REG_ENABLE_TICKS = 3'd0;
    localparam logic [2:0] REG_DATA_WAIT    = 3'd1;
    localparam logic [2:0] REG_COMMAND_WAIT = 3'd2;
    localparam logic [2:0] REG_LONG_WAIT    = 3'd3;
    localparam logic [2:0] REG_BOOTUP_WAIT  = 3'd4;
    localparam logic [2:0] REG_RESET_WAIT   = 3'd5;
    localparam logic [2:0] REG_LINE3_BASE   = 3'd6;
    localparam logic [2:0] REG_LINE4_BASE   = 3'd7;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] value;
        logic [5:0] column;
        logic [2:0] row;
    } item_t;

    typedef struct packed {
        logic [3:0] data_nibble;
        logic       reg_select;
        logic       enable_line;
        logic       busy_res;
        logic       accepted;
    } result_t;

    typedef struct packed {
        logic [7:0]           enable_ticks;
        logic [WAIT_BITS-1:0] data_wait;
        logic [WAIT_BITS-1:0] command_wait;
        logic [WAIT_BITS-1:0] long_wait;
        logic [WAIT_BITS-1:0] bootup_wait;
        logic [WAIT_BITS-1:0] reset_wait;
        logic [6:0]           line3_base;
        logic [6:0]           line4_base;
    } cfg_t;

endpackage

[src/char_lcd_nibble_sequencer_top.sv]
// character lcd sequencer for a 4-bit bus: init, bytes, cursor and timed enable pulses
//
// Each item (a 1 us tick or a request) is taken into an input register, stepped through the
// sequencer state and written to a result register, so one item is accepted every clock
// cycle; the output register's handshake is the only thing that holds the input side back.
// Requests are accepted only while idle (accepted=1); ticks advance the enable pulse and wait
// countdowns, and zero-length waits finish within the same item. The user must write the
// configuration over the apb port only while idle; the block does not enforce this.
module char_lcd_nibble_sequencer_top #(
    parameter int TIMER_BITS = clns_pkg::TIMER_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [clns_pkg::ADDR_BITS-1:0] paddr,
    input  logic [clns_pkg::DATA_BITS-1:0] pwdata,
    output logic [clns_pkg::DATA_BITS-1:0] prdata,
    output logic                           pready,
    input  logic                           item_valid,
    output logic                           item_ready,
    input  clns_pkg::item_t                item,
    output logic                           result_valid,
    input  logic                           result_ready,
    output clns_pkg::result_t              result
);

    localparam logic [31:0] TIMER_MAX = 32'hFFFF_FFFF >> (32 - TIMER_BITS);

    localparam logic [3:0] STEP_NONE   = 4'd0;
    localparam logic [3:0] STEP_BOOT   = 4'd1;
    localparam logic [3:0] STEP_SOFT_A = 4'd2;
    localparam logic [3:0] STEP_WAIT_A = 4'd3;
    localparam logic [3:0] STEP_SOFT_B = 4'd4;
    localparam logic [3:0] STEP_WAIT_B = 4'd5;
    localparam logic [3:0] STEP_SOFT_C = 4'd6;
    localparam logic [3:0] STEP_WAIT_C = 4'd7;
    localparam logic [3:0] STEP_MODE   = 4'd8;
    localparam logic [3:0] STEP_WAIT_D = 4'd9;
    localparam logic [3:0] STEP_FUNC   = 4'd10;
    localparam logic [3:0] STEP_DISP   = 4'd11;
    localparam logic [3:0] STEP_ENTRY  = 4'd12;
    localparam logic [3:0] STEP_CLEAR  = 4'd13;

    localparam logic [3:0] NIB_SOFT_RESET = 4'h3;
    localparam logic [3:0] NIB_MODE_4BIT  = 4'h2;
    localparam logic [7:0] CMD_FUNC_SET   = 8'h28;
    localparam logic [7:0] CMD_DISP_ON    = 8'h0C;
    localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
    localparam logic [7:0] CMD_CLEAR      = 8'h01;
    localparam logic [7:0] CMD_HOME_LAST  = 8'h03;
    localparam logic [7:0] DDRAM_SET      = 8'h80;
    localparam logic [6:0] LINE1_BASE     = 7'h00;
    localparam logic [6:0] LINE2_BASE     = 7'h40;
    localparam logic [7:0] HIGH_MASK      = 8'hF0;
    localparam logic [7:0] LOW_MASK       = 8'h0F;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SETUP,
        PH_PULSE,
        PH_HOLD,
        PH_WAIT,
        PH_LONG
    } phase_t;

    typedef struct packed {
        phase_t                phase;
        logic [TIMER_BITS-1:0] countdown;
        logic [7:0]            byte_reg;
        logic                  rs_reg;
        logic                  low_half;
        logic [3:0]            init_step;
        logic [3:0]            lines;
    } seq_t;

    clns_pkg::cfg_t    cfg_reg;
    seq_t              st_reg;
    seq_t              st_next;
    logic              in_valid_reg;
    clns_pkg::item_t   in_reg;
    logic              out_valid_reg;
    clns_pkg::result_t out_reg;
    clns_pkg::result_t out_next;
    logic              advance;
    logic              cfg_write;

    function automatic logic [TIMER_BITS-1:0] f_sat(logic [clns_pkg::WAIT_BITS-1:0] t);
        logic [TIMER_BITS-1:0] r;
        if (32'(t) > TIMER_MAX)
        begin
            r = '1;
        end
        else
        begin
            r = TIMER_BITS'(t);
        end
        return r;
    endfunction

    function automatic seq_t f_nibble(seq_t s, logic [3:0] n);
        seq_t r;
        r       = s;
        r.lines = n;
        r.phase = PH_SETUP;
        return r;
    endfunction

    function automatic seq_t f_wait(seq_t s, logic [clns_pkg::WAIT_BITS-1:0] t, phase_t p);
        seq_t r;
        r           = s;
        r.countdown = f_sat(t);
        r.phase     = p;
        return r;
    endfunction

    function automatic seq_t f_byte(seq_t s, logic [7:0] b, logic rs);
        seq_t r;
        r          = s;
        r.byte_reg = b;
        r.rs_reg   = rs;
        r.low_half = 1'b0;
        r          = f_nibble(r, 4'((b & HIGH_MASK) >> 4));
        return r;
    endfunction

    function automatic seq_t f_init_next(seq_t s, clns_pkg::cfg_t c);
        seq_t r;
        r           = s;
        r.init_step = s.init_step + 4'd1;
        case (r.init_step)
            STEP_BOOT:   r = f_wait(r, c.bootup_wait, PH_WAIT);
            STEP_SOFT_A: r = f_nibble(r, NIB_SOFT_RESET);
            STEP_SOFT_B: r = f_nibble(r, NIB_SOFT_RESET);
            STEP_SOFT_C: r = f_nibble(r, NIB_SOFT_RESET);
            STEP_WAIT_A: r = f_wait(r, c.reset_wait, PH_WAIT);
            STEP_WAIT_B: r = f_wait(r, c.reset_wait, PH_WAIT);
            STEP_WAIT_C: r = f_wait(r, c.reset_wait, PH_WAIT);
            STEP_WAIT_D: r = f_wait(r, c.reset_wait, PH_WAIT);
            STEP_MODE:   r = f_nibble(r, NIB_MODE_4BIT);
            STEP_FUNC:   r = f_byte(r, CMD_FUNC_SET, 1'b0);
            STEP_DISP:   r = f_byte(r, CMD_DISP_ON, 1'b0);
            STEP_ENTRY:  r = f_byte(r, CMD_ENTRY_MODE, 1'b0);
            STEP_CLEAR:  r = f_byte(r, CMD_CLEAR, 1'b0);
            default:
            begin
                r.init_step = STEP_NONE;
                r.phase     = PH_IDLE;
            end
        endcase
        return r;
    endfunction

    function automatic seq_t f_byte_done(seq_t s, clns_pkg::cfg_t c);
        seq_t r;
        r = s;
        if (s.init_step == STEP_NONE)
        begin
            r.phase = PH_IDLE;
        end
        else
        begin
            r = f_init_next(s, c);
        end
        return r;
    endfunction

    function automatic seq_t f_complete(seq_t s, clns_pkg::cfg_t c);
        seq_t r;
        logic raw_nibble;
        logic init_wait;
        r          = s;
        raw_nibble = s.init_step == STEP_SOFT_A || s.init_step == STEP_SOFT_B ||
                     s.init_step == STEP_SOFT_C || s.init_step == STEP_MODE;
        init_wait  = s.init_step == STEP_BOOT || s.init_step == STEP_WAIT_A ||
                     s.init_step == STEP_WAIT_B || s.init_step == STEP_WAIT_C ||
                     s.init_step == STEP_WAIT_D;
        case (s.phase)
            PH_SETUP:
            begin
                r.phase     = PH_PULSE;
                r.countdown = (c.enable_ticks == 8'd0) ? TIMER_BITS'(1)
                                                       : TIMER_BITS'(c.enable_ticks);
            end
            PH_PULSE:
            begin
                r.phase = PH_HOLD;
            end
            PH_HOLD:
            begin
                if (raw_nibble)
                begin
                    r = f_init_next(s, c);
                end
                else if (!s.low_half)
                begin
                    r.low_half = 1'b1;
                    r          = f_nibble(r, 4'(s.byte_reg & LOW_MASK));
                end
                else
                begin
                    r = f_wait(s, s.rs_reg ? c.data_wait : c.command_wait, PH_WAIT);
                end
            end
            PH_WAIT:
            begin
                if (init_wait)
                begin
                    r = f_init_next(s, c);
                end
                else if (!s.rs_reg && s.byte_reg >= CMD_CLEAR && s.byte_reg <= CMD_HOME_LAST)
                begin
                    r = f_wait(s, c.long_wait, PH_LONG);
                end
                else
                begin
                    r = f_byte_done(s, c);
                end
            end
            PH_LONG:
            begin
                r = f_byte_done(s, c);
            end
            default:
            begin
                r.phase = PH_IDLE;
            end
        endcase
        return r;
    endfunction

    function automatic seq_t f_settle(seq_t s, clns_pkg::cfg_t c);
        seq_t r;
        r = s;
        for (int i = 0; i < 3; i++)
        begin
            if ((r.phase == PH_WAIT || r.phase == PH_LONG) && r.countdown == '0)
            begin
                r = f_complete(r, c);
            end
        end
        return r;
    endfunction

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign advance   = !out_valid_reg || result_ready;
    assign item_ready   = !in_valid_reg || advance;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_comb
    begin
        case (paddr[4:2])
            clns_pkg::REG_ENABLE_TICKS: prdata = 32'(cfg_reg.enable_ticks);
            clns_pkg::REG_DATA_WAIT:    prdata = 32'(cfg_reg.data_wait);
            clns_pkg::REG_COMMAND_WAIT: prdata = 32'(cfg_reg.command_wait);
            clns_pkg::REG_LONG_WAIT:    prdata = 32'(cfg_reg.long_wait);
            clns_pkg::REG_BOOTUP_WAIT:  prdata = 32'(cfg_reg.bootup_wait);
            clns_pkg::REG_RESET_WAIT:   prdata = 32'(cfg_reg.reset_wait);
            clns_pkg::REG_LINE3_BASE:   prdata = 32'(cfg_reg.line3_base);
            clns_pkg::REG_LINE4_BASE:   prdata = 32'(cfg_reg.line4_base);
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable_ticks <= 8'd1;
            cfg_reg.data_wait    <= 20'd46;
            cfg_reg.command_wait <= 20'd42;
            cfg_reg.long_wait    <= 20'd2000;
            cfg_reg.bootup_wait  <= 20'd15000;
            cfg_reg.reset_wait   <= 20'd5000;
            cfg_reg.line3_base   <= 7'd16;
            cfg_reg.line4_base   <= 7'd80;
        end
        else if (cfg_write)
        begin
            case (paddr[4:2])
                clns_pkg::REG_ENABLE_TICKS: cfg_reg.enable_ticks <= pwdata[7:0];
                clns_pkg::REG_DATA_WAIT:    cfg_reg.data_wait    <= pwdata[19:0];
                clns_pkg::REG_COMMAND_WAIT: cfg_reg.command_wait <= pwdata[19:0];
                clns_pkg::REG_LONG_WAIT:    cfg_reg.long_wait    <= pwdata[19:0];
                clns_pkg::REG_BOOTUP_WAIT:  cfg_reg.bootup_wait  <= pwdata[19:0];
                clns_pkg::REG_RESET_WAIT:   cfg_reg.reset_wait   <= pwdata[19:0];
                clns_pkg::REG_LINE3_BASE:   cfg_reg.line3_base   <= pwdata[6:0];
                clns_pkg::REG_LINE4_BASE:   cfg_reg.line4_base   <= pwdata[6:0];
                default:                    cfg_reg.enable_ticks <= cfg_reg.enable_ticks;
            endcase
        end
    end

    always_comb
    begin
        logic [6:0] base;
        logic       row_ok;
        logic       acc;
        seq_t       s;
        s      = st_reg;
        acc    = 1'b0;
        base   = LINE1_BASE;
        row_ok = 1'b1;
        case (in_reg.row)
            3'd1:    base = LINE1_BASE;
            3'd2:    base = LINE2_BASE;
            3'd3:    base = cfg_reg.line3_base;
            3'd4:    base = cfg_reg.line4_base;
            default: row_ok = 1'b0;
        endcase
        if (in_reg.action == clns_pkg::ACT_TICK)
        begin
            if (s.phase == PH_SETUP || s.phase == PH_HOLD)
            begin
                s = f_complete(s, cfg_reg);
            end
            else if (s.phase == PH_PULSE || s.phase == PH_WAIT || s.phase == PH_LONG)
            begin
                s.countdown = s.countdown - TIMER_BITS'(1);
                if (s.countdown == '0)
                begin
                    s = f_complete(s, cfg_reg);
                end
            end
            s = f_settle(s, cfg_reg);
        end
        else if (s.phase == PH_IDLE)
        begin
            case (in_reg.action)
                clns_pkg::ACT_CMD:
                begin
                    s   = f_byte(s, in_reg.value, 1'b0);
                    acc = 1'b1;
                end
                clns_pkg::ACT_DATA:
                begin
                    s   = f_byte(s, in_reg.value, 1'b1);
                    acc = 1'b1;
                end
                clns_pkg::ACT_CURSOR:
                begin
                    if (row_ok)
                    begin
                        s   = f_byte(s, DDRAM_SET + 8'(base) + 8'(in_reg.column), 1'b0);
                        acc = 1'b1;
                    end
                end
                clns_pkg::ACT_INIT:
                begin
                    s.lines     = 4'd0;
                    s.rs_reg    = 1'b0;
                    s.byte_reg  = 8'd0;
                    s.low_half  = 1'b0;
                    s.init_step = STEP_NONE;
                    s           = f_init_next(s, cfg_reg);
                    s           = f_settle(s, cfg_reg);
                    acc         = 1'b1;
                end
                default:
                begin
                    acc = 1'b0;
                end
            endcase
        end
        st_next              = s;
        out_next.data_nibble = s.lines;
        out_next.reg_select  = s.rs_reg;
        out_next.enable_line = s.phase == PH_PULSE;
        out_next.busy_res    = s.phase != PH_IDLE;
        out_next.accepted    = acc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= '{phase: PH_IDLE, default: '0};
            in_valid_reg  <= 1'b0;
            in_reg        <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (item_valid && item_ready)
            begin
                in_valid_reg <= 1'b1;
                in_reg       <= item;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
                if (in_valid_reg)
                begin
                    out_reg <= out_next;
                    st_reg  <= st_next;
                end
            end
        end
    end

endmodule

[tb/char_lcd_nibble_sequencer_check.sv]
// checker for the lcd nibble sequencer: tracks config writes, predicts each result, compares
`timescale 1ns / 1ps
module char_lcd_nibble_sequencer_check (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic                           pready,
    input  logic [clns_pkg::ADDR_BITS-1:0] paddr,
    input  logic [clns_pkg::DATA_BITS-1:0] pwdata,
    input  logic                           item_valid,
    input  logic                           item_ready,
    input  clns_pkg::item_t                item,
    input  logic                           result_valid,
    input  logic                           result_ready,
    input  clns_pkg::result_t              result,
    output int unsigned                    fails
);

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_SETUP,
        SEQ_PULSE,
        SEQ_HOLD,
        SEQ_WAIT,
        SEQ_LONG
    } seq_phase_t;

    clns_pkg::cfg_t                 cfg;
    seq_phase_t                     phase;
    logic [clns_pkg::WAIT_BITS-1:0] countdown;
    logic [7:0]                     byte_q;
    logic                           rs_q;
    logic                           low_half;
    logic [3:0]                     init_step;
    logic [3:0]                     lines;

    clns_pkg::result_t owed_results[$];
    int unsigned       owed_count = 0;
    int unsigned       mismatches = 0;

    // results still owed at the end count as failures too
    assign fails = mismatches + owed_count;

    function automatic void start_nibble(input logic [3:0] n);
        lines = n;
        phase = SEQ_SETUP;
    endfunction

    function automatic void start_wait(input logic [clns_pkg::WAIT_BITS-1:0] t,
                                       input seq_phase_t p);
        countdown = t;
        phase = p;
    endfunction

    function automatic void start_byte(input logic [7:0] b, input logic rs);
        byte_q = b;
        rs_q = rs;
        low_half = 1'b0;
        start_nibble(b[7:4]);
    endfunction

    // power-up sequence: boot wait, three 0x3 nibbles, one 0x2 nibble, then four commands
    function automatic void init_next();
        init_step = init_step + 4'd1;
        case (init_step)
            4'd1:                   start_wait(cfg.bootup_wait, SEQ_WAIT);
            4'd2, 4'd4, 4'd6:       start_nibble(4'h3);
            4'd3, 4'd5, 4'd7, 4'd9: start_wait(cfg.reset_wait, SEQ_WAIT);
            4'd8:                   start_nibble(4'h2);
            4'd10:                  start_byte(8'h28, 1'b0);
            4'd11:                  start_byte(8'h0C, 1'b0);
            4'd12:                  start_byte(8'h06, 1'b0);
            4'd13:                  start_byte(8'h01, 1'b0);
            default:
            begin
                init_step = 4'd0;
                phase = SEQ_IDLE;
            end
        endcase
    endfunction

    function automatic void byte_done();
        if (init_step == 4'd0)
            phase = SEQ_IDLE;
        else
            init_next();
    endfunction

    function automatic void advance();
        case (phase)
            SEQ_SETUP:
            begin
                phase = SEQ_PULSE;
                countdown = (cfg.enable_ticks == 8'd0) ? 20'd1 : {12'd0, cfg.enable_ticks};
            end
            SEQ_PULSE:
                phase = SEQ_HOLD;
            SEQ_HOLD:
            begin
                if (init_step == 4'd2 || init_step == 4'd4 || init_step == 4'd6 ||
                    init_step == 4'd8)
                    init_next();
                else if (!low_half)
                begin
                    low_half = 1'b1;
                    start_nibble(byte_q[3:0]);
                end
                else
                    start_wait(rs_q ? cfg.data_wait : cfg.command_wait, SEQ_WAIT);
            end
            SEQ_WAIT:
            begin
                if (init_step == 4'd1 || init_step == 4'd3 || init_step == 4'd5 ||
                    init_step == 4'd7 || init_step == 4'd9)
                    init_next();
                else if (!rs_q && byte_q >= 8'd1 && byte_q <= 8'd3)
                    start_wait(cfg.long_wait, SEQ_LONG);
                else
                    byte_done();
            end
            SEQ_LONG:
                byte_done();
            default:
                phase = SEQ_IDLE;
        endcase
    endfunction

    // zero-length waits finish within the same item
    function automatic void settle_waits();
        while ((phase == SEQ_WAIT || phase == SEQ_LONG) && countdown == '0)
            advance();
    endfunction

    function automatic clns_pkg::result_t step_sequencer(input clns_pkg::item_t it);
        clns_pkg::result_t r;
        logic              taken;
        logic [6:0]        base;
        taken = 1'b0;
        if (it.action == clns_pkg::ACT_TICK)
        begin
            case (phase)
                SEQ_SETUP, SEQ_HOLD:
                    advance();
                SEQ_PULSE, SEQ_WAIT, SEQ_LONG:
                begin
                    countdown = countdown - 1'b1;
                    if (countdown == '0)
                        advance();
                end
                default:
                    ;
            endcase
            settle_waits();
        end
        else if (phase == SEQ_IDLE)
        begin
            case (it.action)
                clns_pkg::ACT_CMD:
                begin
                    start_byte(it.value, 1'b0);
                    taken = 1'b1;
                end
                clns_pkg::ACT_DATA:
                begin
                    start_byte(it.value, 1'b1);
                    taken = 1'b1;
                end
                clns_pkg::ACT_CURSOR:
                begin
                    if (it.row >= 3'd1 && it.row <= 3'd4)
                    begin
                        case (it.row)
                            3'd1:    base = 7'h00;
                            3'd2:    base = 7'h40;
                            3'd3:    base = cfg.line3_base;
                            default: base = cfg.line4_base;
                        endcase
                        start_byte(8'h80 + {1'b0, base} + {2'b00, it.column}, 1'b0);
                        taken = 1'b1;
                    end
                end
                clns_pkg::ACT_INIT:
                begin
                    lines = 4'd0;
                    rs_q = 1'b0;
                    byte_q = 8'd0;
                    low_half = 1'b0;
                    init_step = 4'd0;
                    init_next();
                    settle_waits();
                    taken = 1'b1;
                end
                default:
                    ;
            endcase
        end
        r.data_nibble = lines;
        r.reg_select  = rs_q;
        r.enable_line = (phase == SEQ_PULSE);
        r.busy_res    = (phase != SEQ_IDLE);
        r.accepted    = taken;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch at %0t: %s", $time, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        clns_pkg::result_t want;
        if (!rst_n)
        begin
            cfg.enable_ticks = 8'd1;
            cfg.data_wait    = 20'd46;
            cfg.command_wait = 20'd42;
            cfg.long_wait    = 20'd2000;
            cfg.bootup_wait  = 20'd15000;
            cfg.reset_wait   = 20'd5000;
            cfg.line3_base   = 7'd16;
            cfg.line4_base   = 7'd80;
            phase = SEQ_IDLE;
            countdown = '0;
            byte_q = 8'd0;
            rs_q = 1'b0;
            low_half = 1'b0;
            init_step = 4'd0;
            lines = 4'd0;
            owed_results.delete();
            owed_count = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (owed_results.size() == 0)
                    report_mismatch($sformatf("result transfer %h with nothing outstanding",
                                              result));
                else
                begin
                    want = owed_results.pop_front();
                    owed_count--;
                    if (result.data_nibble !== want.data_nibble)
                        report_mismatch($sformatf("data_nibble %h, predicted %h",
                                                  result.data_nibble, want.data_nibble));
                    if (result.reg_select !== want.reg_select)
                        report_mismatch($sformatf("reg_select %b, predicted %b",
                                                  result.reg_select, want.reg_select));
                    if (result.enable_line !== want.enable_line)
                        report_mismatch($sformatf("enable_line %b, predicted %b",
                                                  result.enable_line, want.enable_line));
                    if (result.busy_res !== want.busy_res)
                        report_mismatch($sformatf("busy_res %b, predicted %b",
                                                  result.busy_res, want.busy_res));
                    if (result.accepted !== want.accepted)
                        report_mismatch($sformatf("accepted %b, predicted %b",
                                                  result.accepted, want.accepted));
                end
            end
            if (item_valid && item_ready)
            begin
                owed_results.push_back(step_sequencer(item));
                owed_count++;
            end
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    clns_pkg::REG_ENABLE_TICKS:
                        cfg.enable_ticks = pwdata[7:0];
                    clns_pkg::REG_DATA_WAIT:
                        cfg.data_wait    = pwdata[clns_pkg::WAIT_BITS-1:0];
                    clns_pkg::REG_COMMAND_WAIT:
                        cfg.command_wait = pwdata[clns_pkg::WAIT_BITS-1:0];
                    clns_pkg::REG_LONG_WAIT:
                        cfg.long_wait    = pwdata[clns_pkg::WAIT_BITS-1:0];
                    clns_pkg::REG_BOOTUP_WAIT:
                        cfg.bootup_wait  = pwdata[clns_pkg::WAIT_BITS-1:0];
                    clns_pkg::REG_RESET_WAIT:
                        cfg.reset_wait   = pwdata[clns_pkg::WAIT_BITS-1:0];
                    clns_pkg::REG_LINE3_BASE:
                        cfg.line3_base   = pwdata[6:0];
                    default:
                        cfg.line4_base   = pwdata[6:0];
                endcase
            end
        end
    end

endmodule

[tb/char_lcd_nibble_sequencer_top_test.sv]
// top of the lcd nibble sequencer testbench: clock, reset, apb setup, transfers and verdict
`timescale 1ns / 1ps
module char_lcd_nibble_sequencer_top_test;

    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 200;
    localparam int BUS_BITS     = clns_pkg::DATA_BITS;

    logic                           clk     = 1'b0;
    logic                           rst_n   = 1'b0;
    logic                           psel    = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite  = 1'b0;
    logic [clns_pkg::ADDR_BITS-1:0] paddr   = '0;
    logic [BUS_BITS-1:0]            pwdata  = '0;
    logic [BUS_BITS-1:0]            prdata;
    logic                           pready;
    logic                           item_valid = 1'b0;
    logic                           item_ready;
    clns_pkg::item_t                item       = '0;
    logic                           result_valid;
    logic                           result_ready = 1'b0;
    clns_pkg::result_t              result;
    int unsigned                    fails;

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    logic        hold_go       = 1'b0;
    logic        hold_active   = 1'b0;
    int unsigned issued        = 0;
    int unsigned delivered     = 0;
    int unsigned idle_mark     = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    char_lcd_nibble_sequencer_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    char_lcd_nibble_sequencer_check seq_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .fails        (fails)
    );

    always @(posedge clk)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else
            result_ready <= !hold_active && ($urandom_range(99) >= recv_idle_pct);
    end

    // result count and the number of the latest result that showed the block idle
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            delivered <= delivered + 1;
            if (!result.busy_res)
                idle_mark <= delivered + 1;
        end
    end

    initial
    begin
        while (!hold_go)
            @(posedge clk);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active <= 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic clns_pkg::item_t make_item(input logic [2:0] action,
                                                  input logic [7:0] value,
                                                  input logic [5:0] column,
                                                  input logic [2:0] row);
        clns_pkg::item_t it;
        it.action = action;
        it.value  = value;
        it.column = column;
        it.row    = row;
        return it;
    endfunction

    function automatic clns_pkg::item_t tick_item();
        return make_item(clns_pkg::ACT_TICK, 8'($urandom), 6'($urandom), 3'($urandom));
    endfunction

    function automatic clns_pkg::cfg_t random_config();
        clns_pkg::cfg_t c;
        c.enable_ticks = 8'($urandom_range(4));
        c.data_wait    = 20'($urandom_range(12));
        c.command_wait = 20'($urandom_range(12));
        c.long_wait    = 20'($urandom_range(30));
        c.bootup_wait  = 20'($urandom_range(20));
        c.reset_wait   = 20'($urandom_range(20));
        c.line3_base   = 7'($urandom_range(127));
        c.line4_base   = 7'($urandom_range(127));
        return c;
    endfunction

    task automatic offer(input clns_pkg::item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        issued++;
    endtask

    // ticks until the block reports idle, then wait for every result
    task automatic settle_idle();
        int unsigned mark;
        mark = issued;
        while (idle_mark < mark)
            offer(tick_item());
        item_valid <= 1'b0;
        while (delivered != issued)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [BUS_BITS-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_config(input clns_pkg::cfg_t c);
        write_reg(clns_pkg::REG_ENABLE_TICKS, BUS_BITS'(c.enable_ticks));
        write_reg(clns_pkg::REG_DATA_WAIT,    BUS_BITS'(c.data_wait));
        write_reg(clns_pkg::REG_COMMAND_WAIT, BUS_BITS'(c.command_wait));
        write_reg(clns_pkg::REG_LONG_WAIT,    BUS_BITS'(c.long_wait));
        write_reg(clns_pkg::REG_BOOTUP_WAIT,  BUS_BITS'(c.bootup_wait));
        write_reg(clns_pkg::REG_RESET_WAIT,   BUS_BITS'(c.reset_wait));
        write_reg(clns_pkg::REG_LINE3_BASE,   BUS_BITS'(c.line3_base));
        write_reg(clns_pkg::REG_LINE4_BASE,   BUS_BITS'(c.line4_base));
    endtask

    task automatic random_items(input int count);
        int unsigned     pick;
        clns_pkg::item_t it;
        repeat (count)
        begin
            pick = $urandom_range(99);
            it = tick_item();
            if (pick >= 60 && pick < 70)
            begin
                it.action = clns_pkg::ACT_CMD;
                if ($urandom_range(3) == 0)
                    it.value = 8'($urandom_range(3));
            end
            else if (pick >= 70 && pick < 80)
                it.action = clns_pkg::ACT_DATA;
            else if (pick >= 80 && pick < 90)
                it.action = clns_pkg::ACT_CURSOR;
            else if (pick >= 90 && pick < 95)
                it.action = clns_pkg::ACT_INIT;
            else if (pick >= 95)
                it.action = 3'($urandom_range(7, 5));
            offer(it);
        end
    endtask

    initial
    begin
        clns_pkg::cfg_t c;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct <= 25;
        recv_idle_pct <= 45;

        c.enable_ticks = 8'd1;
        c.data_wait    = 20'd3;
        c.command_wait = 20'd2;
        c.long_wait    = 20'd5;
        c.bootup_wait  = 20'd4;
        c.reset_wait   = 20'd2;
        c.line3_base   = 7'd0;
        c.line4_base   = 7'd127;
        load_config(c);

        // tick while idle, init with a request refused while busy
        offer(make_item(clns_pkg::ACT_TICK, 8'hFF, 6'h3F, 3'd7));
        offer(make_item(clns_pkg::ACT_INIT, 8'h00, 6'h00, 3'd0));
        offer(make_item(clns_pkg::ACT_CMD, 8'h55, 6'h00, 3'd0));
        settle_idle();
        // commands, clear and home get the long wait
        offer(make_item(clns_pkg::ACT_CMD, 8'h00, 6'h00, 3'd0));
        settle_idle();
        offer(make_item(clns_pkg::ACT_CMD, 8'hFF, 6'h00, 3'd0));
        settle_idle();
        offer(make_item(clns_pkg::ACT_CMD, 8'h01, 6'h00, 3'd0));
        settle_idle();
        offer(make_item(clns_pkg::ACT_CMD, 8'h02, 6'h00, 3'd0));
        settle_idle();
        offer(make_item(clns_pkg::ACT_CMD, 8'h03, 6'h00, 3'd0));
        settle_idle();
        // data bytes never get the long wait
        offer(make_item(clns_pkg::ACT_DATA, 8'h01, 6'h00, 3'd0));
        settle_idle();
        offer(make_item(clns_pkg::ACT_DATA, 8'h00, 6'h00, 3'd0));
        settle_idle();
        offer(make_item(clns_pkg::ACT_DATA, 8'hFF, 6'h00, 3'd0));
        settle_idle();
        // cursor rows, wrap past 8 bits, invalid rows
        offer(make_item(clns_pkg::ACT_CURSOR, 8'h00, 6'h00, 3'd1));
        settle_idle();
        offer(make_item(clns_pkg::ACT_CURSOR, 8'h00, 6'h3F, 3'd2));
        settle_idle();
        offer(make_item(clns_pkg::ACT_CURSOR, 8'h00, 6'h3F, 3'd3));
        settle_idle();
        offer(make_item(clns_pkg::ACT_CURSOR, 8'hFF, 6'h3F, 3'd4));
        settle_idle();
        offer(make_item(clns_pkg::ACT_CURSOR, 8'h00, 6'h15, 3'd0));
        offer(make_item(clns_pkg::ACT_CURSOR, 8'h00, 6'h2A, 3'd5));
        offer(make_item(clns_pkg::ACT_CURSOR, 8'h00, 6'h3F, 3'd7));
        // unknown actions
        offer(make_item(3'd5, 8'hA5, 6'h2A, 3'd1));
        offer(make_item(3'd6, 8'h5A, 6'h15, 3'd2));
        offer(make_item(3'd7, 8'hFF, 6'h3F, 3'd4));
        settle_idle();

        // zero enable ticks and zero waits
        c.enable_ticks = 8'd0;
        c.data_wait    = 20'd0;
        c.command_wait = 20'd0;
        c.long_wait    = 20'd0;
        c.bootup_wait  = 20'd0;
        c.reset_wait   = 20'd0;
        c.line3_base   = 7'd127;
        c.line4_base   = 7'd0;
        load_config(c);
        random_items(RANDOM_ITEMS);
        settle_idle();

        // longest enable pulse
        c.enable_ticks = 8'd255;
        c.data_wait    = 20'd5;
        c.command_wait = 20'd5;
        c.long_wait    = 20'd7;
        c.bootup_wait  = 20'd3;
        c.reset_wait   = 20'd3;
        load_config(c);
        offer(make_item(clns_pkg::ACT_CMD, 8'h01, 6'h00, 3'd0));
        settle_idle();

        // longest waits, block kept idle
        c.enable_ticks = 8'($urandom_range(255, 1));
        c.data_wait    = 20'hFFFFF;
        c.command_wait = 20'hFFFFF;
        c.long_wait    = 20'hFFFFF;
        c.bootup_wait  = 20'hFFFFF;
        c.reset_wait   = 20'hFFFFF;
        c.line3_base   = 7'd64;
        c.line4_base   = 7'd63;
        load_config(c);
        repeat (40)
        begin
            case ($urandom_range(2))
                0:       offer(tick_item());
                1:       offer(make_item(3'($urandom_range(7, 5)), 8'($urandom),
                                         6'($urandom), 3'($urandom)));
                default: offer(make_item(clns_pkg::ACT_CURSOR, 8'($urandom), 6'($urandom),
                                         ($urandom_range(1) == 0) ? 3'd0 :
                                         3'($urandom_range(7, 5))));
            endcase
        end
        settle_idle();

        send_idle_pct <= 45;
        recv_idle_pct <= 25;
        load_config(random_config());
        hold_go <= 1'b1;
        random_items(RANDOM_ITEMS);
        settle_idle();

        load_config(random_config());
        random_items(RANDOM_ITEMS);
        settle_idle();

        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        load_config(random_config());
        random_items(RANDOM_ITEMS);
        settle_idle();

        if (fails == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
